// ===== hdl/qrvs_pkg.sv =====
// Package: shared types, constants and step functions for the quadratic solver.
`default_nettype none
package qrvs_pkg;

    // Datapath widths
    localparam int COEF_W     = 16;
    localparam int RES_W      = 32;
    localparam int DISC_W     = 35;
    localparam int SQ_W       = 64;
    localparam int SQ_STAGES  = 32;
    localparam int NUM_W      = 40;
    localparam int DEN_W      = 16;
    localparam int DIV_STAGES = NUM_W;
    localparam int LANES      = 4;

    // Divider lane roles
    localparam int LANE_VX  = 0;
    localparam int LANE_VY  = 1;
    localparam int LANE_R1  = 2;
    localparam int LANE_R2  = 3;

    // Opening direction codes
    localparam logic [1:0] OPEN_NONE = 2'd0;
    localparam logic [1:0] OPEN_UP   = 2'd1;
    localparam logic [1:0] OPEN_DOWN = 2'd2;

    // Root count codes
    localparam logic [1:0] CNT_NONE = 2'd0;
    localparam logic [1:0] CNT_ONE  = 2'd1;
    localparam logic [1:0] CNT_TWO  = 2'd2;

    typedef struct packed {
        logic signed [COEF_W-1:0] coef_quad;
        logic signed [COEF_W-1:0] coef_lin;
        logic signed [COEF_W-1:0] coef_const;
    } qrvs_in_t;

    typedef struct packed {
        logic [1:0]              root_count;
        logic signed [RES_W-1:0] root_first;
        logic signed [RES_W-1:0] root_second;
        logic signed [RES_W-1:0] vertex_x;
        logic signed [RES_W-1:0] vertex_y;
        logic                    vertex_valid;
        logic [1:0]              opening;
        logic                    saturated;
    } qrvs_out_t;

    typedef struct packed {
        logic [DEN_W:0]   rem;
        logic [NUM_W-1:0] nq;
    } div_st_t;

    typedef struct packed {
        logic [SQ_W-1:0] rem;
        logic [SQ_W-1:0] res;
    } sq_st_t;

    typedef struct packed {
        logic [RES_W-1:0] val;
        logic             sat;
    } clip_t;

    // One restoring-division step: bring in the next numerator bit, subtract if it fits
    function automatic div_st_t div_step(div_st_t s, logic [DEN_W-1:0] d);
        logic [DEN_W:0] shifted;
        div_st_t        o;
        shifted = {s.rem[DEN_W-1:0], s.nq[NUM_W-1]};
        if (shifted >= {1'b0, d}) begin
            o.rem = shifted - {1'b0, d};
            o.nq  = {s.nq[NUM_W-2:0], 1'b1};
        end
        else begin
            o.rem = shifted;
            o.nq  = {s.nq[NUM_W-2:0], 1'b0};
        end
        return o;
    endfunction

    // One digit of the integer square root
    function automatic sq_st_t sqrt_step(sq_st_t s, logic [SQ_W-1:0] bitv);
        sq_st_t o;
        if (s.rem >= s.res + bitv) begin
            o.rem = s.rem - (s.res + bitv);
            o.res = (s.res >> 1) + bitv;
        end
        else begin
            o.rem = s.rem;
            o.res = s.res >> 1;
        end
        return o;
    endfunction

    // Apply sign to a quotient magnitude and clip to the signed 32-bit range
    function automatic clip_t clip32(logic neg, logic [NUM_W-1:0] q);
        clip_t o;
        if (!neg && q > NUM_W'(32'h7FFF_FFFF)) begin
            o.val = 32'h7FFF_FFFF;
            o.sat = 1'b1;
        end
        else if (neg && q > NUM_W'(32'h8000_0000)) begin
            o.val = 32'h8000_0000;
            o.sat = 1'b1;
        end
        else begin
            o.val = neg ? (~q[RES_W-1:0] + 1'b1) : q[RES_W-1:0];
            o.sat = 1'b0;
        end
        return o;
    endfunction

endpackage
`default_nettype wire

// ===== hdl/qrvs_div_pipe.sv =====
// Pipelined restoring divider: one quotient bit per stage, unsigned operands.
`default_nettype none
module qrvs_div_pipe (
    input  wire logic                          clk,
    input  wire logic                          en,
    input  wire logic [qrvs_pkg::NUM_W-1:0]    num,
    input  wire logic [qrvs_pkg::DEN_W-1:0]    den,
    output logic      [qrvs_pkg::NUM_W-1:0]    quo
);

    qrvs_pkg::div_st_t                 st_reg [qrvs_pkg::DIV_STAGES];
    logic [qrvs_pkg::DEN_W-1:0]        d_reg  [qrvs_pkg::DIV_STAGES];
    qrvs_pkg::div_st_t                 st_in;

    // Seed the first step with a clear remainder
    always_comb
    begin
        st_in.rem = '0;
        st_in.nq  = num;
    end

    // Advance every stage by one quotient bit
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            st_reg[0] <= qrvs_pkg::div_step(st_in, den);
            d_reg[0]  <= den;
            for (int i = 1; i < qrvs_pkg::DIV_STAGES; i++)
            begin
                st_reg[i] <= qrvs_pkg::div_step(st_reg[i-1], d_reg[i-1]);
                d_reg[i]  <= d_reg[i-1];
            end
        end
    end

    assign quo = st_reg[qrvs_pkg::DIV_STAGES-1].nq;

endmodule
`default_nettype wire

// ===== hdl/quadratic_root_vertex_solver.sv =====
// Stage order: input, multiply, square root, preparation, dividers, output register.
// Throughput: one transaction per cycle; the whole pipe advances whenever the output
// register is empty or being taken, so a stall holds every stage in place.
// Depth is set by the 32-stage square root and the 40-stage dividers.
// Reset (rst_n low, asynchronous) clears all stage valid bits; no other state.
`default_nettype none
module quadratic_root_vertex_solver (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire qrvs_pkg::qrvs_in_t   in_data,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output qrvs_pkg::qrvs_out_t       out_data
);

    typedef struct packed {
        logic signed [qrvs_pkg::COEF_W-1:0] a;
        logic signed [qrvs_pkg::COEF_W-1:0] b;
        logic signed [qrvs_pkg::COEF_W-1:0] c;
        logic signed [qrvs_pkg::DISC_W-1:0] disc;
    } side_t;

    typedef struct packed {
        logic [1:0] count;
        logic [1:0] opening;
        logic       vvalid;
        logic       r1_lane0;
    } info_t;

    logic en;

    // Input and multiply stages
    qrvs_pkg::qrvs_in_t in_reg;
    logic               in_v_reg;
    qrvs_pkg::qrvs_in_t m_reg;
    logic signed [31:0] bb_reg;
    logic signed [31:0] ac_reg;
    logic               m_v_reg;

    // Square root stages
    side_t              sq_side_reg [qrvs_pkg::SQ_STAGES+1];
    qrvs_pkg::sq_st_t   sq_st_reg   [qrvs_pkg::SQ_STAGES+1];
    logic               sq_v_reg    [qrvs_pkg::SQ_STAGES+1];
    logic signed [qrvs_pkg::DISC_W-1:0] disc_next;

    // Divider preparation stage
    logic [qrvs_pkg::NUM_W-1:0] num_reg [qrvs_pkg::LANES];
    logic [qrvs_pkg::DEN_W-1:0] den_reg [qrvs_pkg::LANES];
    logic                       neg_reg [qrvs_pkg::LANES];
    info_t                      prep_info_reg;
    logic                       prep_v_reg;

    logic [qrvs_pkg::NUM_W-1:0] num_next [qrvs_pkg::LANES];
    logic [qrvs_pkg::DEN_W-1:0] den_next [qrvs_pkg::LANES];
    logic                       neg_next [qrvs_pkg::LANES];
    info_t                      info_next;

    // Divider side pipe
    logic [qrvs_pkg::LANES-1:0] dneg_reg  [qrvs_pkg::DIV_STAGES];
    info_t                      dinfo_reg [qrvs_pkg::DIV_STAGES];
    logic                       dv_reg    [qrvs_pkg::DIV_STAGES];
    logic [qrvs_pkg::NUM_W-1:0] quo       [qrvs_pkg::LANES];

    // Output stage
    qrvs_pkg::qrvs_out_t out_reg;
    qrvs_pkg::qrvs_out_t out_next;
    logic                out_v_reg;

    // Advance the whole pipe when the output register is free or taken
    assign en       = !out_v_reg || out_ready;
    assign in_ready = en;
    assign out_valid = out_v_reg;
    assign out_data  = out_reg;

    // Form the discriminant from the registered products
    assign disc_next = qrvs_pkg::DISC_W'(bb_reg) - (qrvs_pkg::DISC_W'(ac_reg) <<< 2);

    // Build numerators, divisor magnitudes and signs for the four divider lanes
    always_comb
    begin
        side_t                                  sd;
        logic [31:0]                            s;
        logic signed [qrvs_pkg::NUM_W:0]        nb;
        logic signed [qrvs_pkg::NUM_W:0]        n   [qrvs_pkg::LANES];
        logic signed [qrvs_pkg::DEN_W-1:0]      d   [qrvs_pkg::LANES];
        logic [qrvs_pkg::NUM_W:0]               mag;
        logic [qrvs_pkg::DEN_W-1:0]             ud;
        logic                                   a_zero;
        sd     = sq_side_reg[qrvs_pkg::SQ_STAGES];
        s      = sq_st_reg[qrvs_pkg::SQ_STAGES].res[31:0];
        a_zero = (sd.a == '0);
        nb     = -((qrvs_pkg::NUM_W+1)'(sd.b) <<< 15);
        n[qrvs_pkg::LANE_VX] = a_zero ? -((qrvs_pkg::NUM_W+1)'(sd.c) <<< 16) : nb;
        n[qrvs_pkg::LANE_VY] = -((qrvs_pkg::NUM_W+1)'(sd.disc) <<< 6);
        n[qrvs_pkg::LANE_R1] = nb + $signed({9'd0, s});
        n[qrvs_pkg::LANE_R2] = nb - $signed({9'd0, s});
        d[qrvs_pkg::LANE_VX] = a_zero ? sd.b : sd.a;
        d[qrvs_pkg::LANE_VY] = sd.a;
        d[qrvs_pkg::LANE_R1] = sd.a;
        d[qrvs_pkg::LANE_R2] = sd.a;
        for (int i = 0; i < qrvs_pkg::LANES; i++)
        begin
            mag         = n[i][qrvs_pkg::NUM_W] ? -n[i] : n[i];
            ud          = d[i][qrvs_pkg::DEN_W-1] ? -d[i] : d[i];
            num_next[i] = mag[qrvs_pkg::NUM_W-1:0] + qrvs_pkg::NUM_W'(ud >> 1);
            den_next[i] = ud;
            neg_next[i] = n[i][qrvs_pkg::NUM_W] ^ d[i][qrvs_pkg::DEN_W-1];
        end

        info_next.r1_lane0 = 1'b1;
        if (a_zero)
        begin
            info_next.opening = qrvs_pkg::OPEN_NONE;
            info_next.vvalid  = 1'b0;
            info_next.count   = (sd.b != '0) ? qrvs_pkg::CNT_ONE : qrvs_pkg::CNT_NONE;
        end
        else
        begin
            info_next.opening = sd.a[qrvs_pkg::COEF_W-1] ? qrvs_pkg::OPEN_DOWN
                                                         : qrvs_pkg::OPEN_UP;
            info_next.vvalid  = 1'b1;
            if (sd.disc > 0)
            begin
                info_next.count    = qrvs_pkg::CNT_TWO;
                info_next.r1_lane0 = 1'b0;
            end
            else if (sd.disc == 0)
            begin
                info_next.count = qrvs_pkg::CNT_ONE;
            end
            else
            begin
                info_next.count = qrvs_pkg::CNT_NONE;
            end
        end
    end

    // Divider lanes
    for (genvar g = 0; g < qrvs_pkg::LANES; g++)
    begin : g_div
        qrvs_div_pipe u_div (
            .clk (clk),
            .en  (en),
            .num (num_reg[g]),
            .den (den_reg[g]),
            .quo (quo[g])
        );
    end

    // Sign, clip and select the reported values
    always_comb
    begin
        qrvs_pkg::clip_t      cl [qrvs_pkg::LANES];
        info_t                inf;
        logic [qrvs_pkg::LANES-1:0] ng;
        logic                 r1_sat;
        inf = dinfo_reg[qrvs_pkg::DIV_STAGES-1];
        ng  = dneg_reg[qrvs_pkg::DIV_STAGES-1];
        for (int i = 0; i < qrvs_pkg::LANES; i++)
        begin
            cl[i] = qrvs_pkg::clip32(ng[i], quo[i]);
        end
        r1_sat = inf.r1_lane0 ? cl[qrvs_pkg::LANE_VX].sat : cl[qrvs_pkg::LANE_R1].sat;

        out_next.root_count   = inf.count;
        out_next.vertex_valid = inf.vvalid;
        out_next.opening      = inf.opening;
        out_next.root_first   = '0;
        out_next.root_second  = '0;
        out_next.vertex_x     = '0;
        out_next.vertex_y     = '0;
        if (inf.count != qrvs_pkg::CNT_NONE)
        begin
            out_next.root_first = inf.r1_lane0 ? cl[qrvs_pkg::LANE_VX].val
                                               : cl[qrvs_pkg::LANE_R1].val;
        end
        if (inf.count == qrvs_pkg::CNT_TWO)
        begin
            out_next.root_second = cl[qrvs_pkg::LANE_R2].val;
        end
        if (inf.vvalid)
        begin
            out_next.vertex_x = cl[qrvs_pkg::LANE_VX].val;
            out_next.vertex_y = cl[qrvs_pkg::LANE_VY].val;
        end
        out_next.saturated =
            (inf.vvalid && (cl[qrvs_pkg::LANE_VX].sat || cl[qrvs_pkg::LANE_VY].sat)) ||
            ((inf.count != qrvs_pkg::CNT_NONE) && r1_sat) ||
            ((inf.count == qrvs_pkg::CNT_TWO) && cl[qrvs_pkg::LANE_R2].sat);
    end

    // Hold or advance the payload registers
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            in_reg <= in_data;
            m_reg  <= in_reg;
            bb_reg <= in_reg.coef_lin * in_reg.coef_lin;
            ac_reg <= in_reg.coef_quad * in_reg.coef_const;

            sq_side_reg[0].a    <= m_reg.coef_quad;
            sq_side_reg[0].b    <= m_reg.coef_lin;
            sq_side_reg[0].c    <= m_reg.coef_const;
            sq_side_reg[0].disc <= disc_next;
            sq_st_reg[0].res    <= '0;
            sq_st_reg[0].rem    <= (disc_next > 0) ? (qrvs_pkg::SQ_W'(disc_next) << 30) : '0;
            for (int i = 1; i <= qrvs_pkg::SQ_STAGES; i++)
            begin
                sq_side_reg[i] <= sq_side_reg[i-1];
                sq_st_reg[i]   <= qrvs_pkg::sqrt_step(sq_st_reg[i-1],
                                      qrvs_pkg::SQ_W'(1) << (7'(64 - 2 * i)));
            end

            for (int i = 0; i < qrvs_pkg::LANES; i++)
            begin
                num_reg[i]     <= num_next[i];
                den_reg[i]     <= den_next[i];
                neg_reg[i]     <= neg_next[i];
                dneg_reg[0][i] <= neg_reg[i];
            end
            prep_info_reg <= info_next;
            dinfo_reg[0]  <= prep_info_reg;
            for (int i = 1; i < qrvs_pkg::DIV_STAGES; i++)
            begin
                dneg_reg[i]  <= dneg_reg[i-1];
                dinfo_reg[i] <= dinfo_reg[i-1];
            end

            out_reg <= out_next;
        end
    end

    // Advance the valid bits with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_v_reg   <= 1'b0;
            m_v_reg    <= 1'b0;
            prep_v_reg <= 1'b0;
            out_v_reg  <= 1'b0;
            for (int i = 0; i <= qrvs_pkg::SQ_STAGES; i++)
            begin
                sq_v_reg[i] <= 1'b0;
            end
            for (int i = 0; i < qrvs_pkg::DIV_STAGES; i++)
            begin
                dv_reg[i] <= 1'b0;
            end
        end
        else if (en)
        begin
            in_v_reg    <= in_valid;
            m_v_reg     <= in_v_reg;
            sq_v_reg[0] <= m_v_reg;
            for (int i = 1; i <= qrvs_pkg::SQ_STAGES; i++)
            begin
                sq_v_reg[i] <= sq_v_reg[i-1];
            end
            prep_v_reg <= sq_v_reg[qrvs_pkg::SQ_STAGES];
            dv_reg[0]  <= prep_v_reg;
            for (int i = 1; i < qrvs_pkg::DIV_STAGES; i++)
            begin
                dv_reg[i] <= dv_reg[i-1];
            end
            out_v_reg <= dv_reg[qrvs_pkg::DIV_STAGES-1];
        end
    end

endmodule
`default_nettype wire

// ===== dv/testbench.sv =====
// Testbench for the quadratic root and vertex solver: directed table plus random equations.
`default_nettype none
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY     = 77;
    localparam int IDLE_LIMIT  = 20000;
    localparam int RANDOM_ITEMS = 750;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    qrvs_pkg::qrvs_in_t  in_data;
    logic                out_valid;
    logic                out_ready;
    qrvs_pkg::qrvs_out_t out_data;

    quadratic_root_vertex_solver dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data (out_data)
    );

    // Directed row: coefficients, and a typed-in answer where it is obvious
    typedef struct {
        logic signed [15:0]  a;
        logic signed [15:0]  b;
        logic signed [15:0]  c;
        bit                  typed;
        qrvs_pkg::qrvs_out_t answer;
    } row_t;

    qrvs_pkg::qrvs_out_t solutions_q[$];
    int                  mismatches;
    int                  idle_cycles = 0;
    bit                  stim_done;

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Rounded quotient, ties away from zero
    function automatic longint round_div(longint n, longint d);
        longint un;
        longint ud;
        longint q;
        un = (n < 0) ? -n : n;
        ud = (d < 0) ? -d : d;
        q  = (un + ud / 2) / ud;
        return (((n < 0) != (d < 0)) ? -q : q);
    endfunction

    // Integer square root of a 64-bit magnitude, digit by digit
    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned res;
        longint unsigned bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > v)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (v >= res + bitv)
            begin
                v   = v - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res = res >> 1;
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic logic [31:0] clip_q16(longint v, inout bit sat);
        if (v > 64'sd2147483647)
        begin
            sat = 1'b1;
            return 32'h7FFF_FFFF;
        end
        if (v < -64'sd2147483648)
        begin
            sat = 1'b1;
            return 32'h8000_0000;
        end
        return v[31:0];
    endfunction

    // Solve one equation
    function automatic qrvs_pkg::qrvs_out_t solve_quadratic(qrvs_pkg::qrvs_in_t x);
        qrvs_pkg::qrvs_out_t r;
        longint    a;
        longint    b;
        longint    c;
        longint    disc;
        longint    s;
        bit        sat;
        a   = x.coef_quad;
        b   = x.coef_lin;
        c   = x.coef_const;
        sat = 1'b0;
        r   = '0;
        r.root_count = qrvs_pkg::CNT_NONE;
        r.opening    = qrvs_pkg::OPEN_NONE;
        if (a == 0)
        begin
            if (b != 0)
            begin
                r.root_count = qrvs_pkg::CNT_ONE;
                r.root_first = clip_q16(round_div(-c * 65536, b), sat);
            end
        end
        else
        begin
            disc = b * b - 4 * a * c;
            r.opening      = (a > 0) ? qrvs_pkg::OPEN_UP : qrvs_pkg::OPEN_DOWN;
            r.vertex_valid = 1'b1;
            r.vertex_x     = clip_q16(round_div(-b * 32768, a), sat);
            r.vertex_y     = clip_q16(round_div(-disc * 64, a), sat);
            if (disc > 0)
            begin
                s = longint'(int_sqrt(longint'(disc) << 30));
                r.root_count  = qrvs_pkg::CNT_TWO;
                r.root_first  = clip_q16(round_div(-b * 32768 + s, a), sat);
                r.root_second = clip_q16(round_div(-b * 32768 - s, a), sat);
            end
            else if (disc == 0)
            begin
                r.root_count = qrvs_pkg::CNT_ONE;
                r.root_first = r.vertex_x;
            end
        end
        r.saturated = sat;
        return r;
    endfunction

    function automatic logic signed [15:0] rand_coef();
        case ($urandom_range(0, 9))
            0:       return 16'sh0000;
            1:       return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
            2, 3, 4: return 16'(int'($urandom_range(0, 2047)) - 1024);
            5, 6:    return 16'(int'($urandom_range(0, 15)) - 8) <<< 8;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic int gap_len();
        if ($urandom_range(0, 3) == 0)
            return 0;
        return ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 3);
    endfunction

    // Hand one transaction to the block
    task automatic send_equation(qrvs_pkg::qrvs_in_t x, qrvs_pkg::qrvs_out_t answer);
        in_valid <= 1'b1;
        in_data  <= x;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        solutions_q.insert(solutions_q.size(), answer);
    endtask

    task automatic idle_input(int n);
        if (n > 0)
        begin
            in_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    // Stimulus
    initial
    begin
        row_t                rows[$];
        row_t                rw;
        qrvs_pkg::qrvs_in_t  x;
        qrvs_pkg::qrvs_out_t ans;
        in_valid  = 1'b0;
        in_data   = '0;
        rst_n     = 1'b0;
        stim_done = 1'b0;
        // Degenerate: no root at all, even with c zero
        rw = '{16'sd0, 16'sd0, 16'sd0, 1'b1, '0};
        rows.insert(rows.size(), rw);
        rw = '{16'sd0, 16'sd0, 16'sh7FFF, 1'b1, '0};
        rows.insert(rows.size(), rw);
        // Linear: x = -c/b = -2
        rw = '{16'sd0, 16'sh0100, 16'sh0200, 1'b1, '0};
        rw.answer.root_count = qrvs_pkg::CNT_ONE;
        rw.answer.root_first = -32'sh0002_0000;
        rows.insert(rows.size(), rw);
        // x^2 - 1: roots +1, -1, vertex (0, -1)
        rw = '{16'sh0100, 16'sd0, -16'sh0100, 1'b1, '0};
        rw.answer.root_count   = qrvs_pkg::CNT_TWO;
        rw.answer.root_first   = 32'sh0001_0000;
        rw.answer.root_second  = -32'sh0001_0000;
        rw.answer.vertex_y     = -32'sh0001_0000;
        rw.answer.vertex_valid = 1'b1;
        rw.answer.opening      = qrvs_pkg::OPEN_UP;
        rows.insert(rows.size(), rw);
        // Double root, negative discriminant, downward, extremes, saturation
        rw = '{16'sh0100, -16'sh0200, 16'sh0100, 1'b0, '0};   rows.insert(rows.size(), rw);
        rw = '{16'sh0100, 16'sd0, 16'sh0100, 1'b0, '0};       rows.insert(rows.size(), rw);
        rw = '{-16'sh0100, 16'sh0100, 16'sh0200, 1'b0, '0};   rows.insert(rows.size(), rw);
        rw = '{16'sh0001, 16'sh7FFF, 16'sh8000, 1'b0, '0};    rows.insert(rows.size(), rw);
        rw = '{16'sh0001, 16'sh8000, 16'sh7FFF, 1'b0, '0};    rows.insert(rows.size(), rw);
        rw = '{16'sh8000, 16'sh8000, 16'sh8000, 1'b0, '0};    rows.insert(rows.size(), rw);
        rw = '{16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 1'b0, '0};    rows.insert(rows.size(), rw);
        rw = '{16'sh7FFF, 16'sh8000, 16'sh8000, 1'b0, '0};    rows.insert(rows.size(), rw);
        rw = '{16'sh8000, 16'sh7FFF, 16'sh7FFF, 1'b0, '0};    rows.insert(rows.size(), rw);
        rw = '{16'sd0, 16'sh0001, 16'sh8000, 1'b0, '0};       rows.insert(rows.size(), rw);
        rw = '{16'sd0, 16'shFFFF, 16'sh7FFF, 1'b0, '0};       rows.insert(rows.size(), rw);
        rw = '{16'sd0, 16'sh8000, 16'sh0001, 1'b0, '0};       rows.insert(rows.size(), rw);
        rw = '{-16'sh0001, 16'sd0, 16'sd0, 1'b0, '0};         rows.insert(rows.size(), rw);
        rw = '{16'sh0003, 16'sh0007, 16'sh0002, 1'b0, '0};    rows.insert(rows.size(), rw);
        rw = '{16'shFFFF, 16'shFFFF, 16'shFFFF, 1'b0, '0};    rows.insert(rows.size(), rw);
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        // Walk the directed table
        foreach (rows[i])
        begin
            x   = '{rows[i].a, rows[i].b, rows[i].c};
            ans = rows[i].typed ? rows[i].answer : solve_quadratic(x);
            send_equation(x, ans);
            idle_input(gap_len());
        end
        // Random equations, some built around a double root
        repeat (RANDOM_ITEMS)
        begin
            x.coef_quad = rand_coef();
            x.coef_lin  = rand_coef();
            x.coef_const = rand_coef();
            if ($urandom_range(0, 9) == 0)
            begin
                // b = 2k, a = 1, c = k*k gives a zero discriminant
                x.coef_quad  = 16'sd1;
                x.coef_lin   = 16'(2 * (int'($urandom_range(0, 255)) - 128));
                x.coef_const = 16'((int'(x.coef_lin) / 2) * (int'(x.coef_lin) / 2));
            end
            send_equation(x, solve_quadratic(x));
            idle_input(gap_len());
        end
        in_valid  <= 1'b0;
        stim_done <= 1'b1;
    end

    // Result side: random stalls, compare against the oldest expectation
    initial
    begin
        qrvs_pkg::qrvs_out_t want;
        int                  stall;
        out_ready  = 1'b0;
        mismatches = 0;
        @(posedge rst_n);
        forever
        begin
            stall = gap_len();
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            if (out_valid)
            begin
                if (solutions_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result transaction %p", out_data);
                end
                else
                begin
                    want = solutions_q.pop_front();
                    if (out_data !== want)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected %p, got %p", want, out_data);
                    end
                end
            end
        end
    end

    // Watchdog: count cycles with no transaction on either side, stop a stuck run
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles + 1 >= IDLE_LIMIT)
            begin
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    // End of run
    initial
    begin
        @(posedge stim_done);
        while (solutions_q.size() != 0 && idle_cycles < IDLE_LIMIT)
            @(posedge clk);
        if (solutions_q.size() != 0)
        begin
            $display("*** FAILED ***");
        end
        else
        begin
            repeat (2 * LATENCY) @(posedge clk);
            if (mismatches == 0)
                $display("*** PASSED ***");
            else
                $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
`default_nettype wire

// ===== filelist.f =====
hdl/qrvs_pkg.sv
hdl/qrvs_div_pipe.sv
hdl/quadratic_root_vertex_solver.sv
dv/testbench.sv
